// File: sv/lpwb_pkg.sv
package lpwb_pkg;

  localparam int unsigned NumLayers  = 4;
  localparam int unsigned ChanW      = 5;
  localparam int unsigned NumChans   = 3;
  localparam int unsigned PixelW     = 16;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned WeightMax  = 16;
  localparam logic [ChanW-1:0] ChanMax = 5'h1F;
  localparam logic [PixelW-1:0] BlankPixel = 16'hFFFF;

  // Register indexes on the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_LAYER_CTRL  = 3'd0,
    REG_EFFECT_CTRL = 3'd1,
    REG_BLEND_WGT   = 3'd2,
    REG_BRIGHT      = 3'd3,
    REG_WIN0_RECT   = 3'd4,
    REG_WIN1_RECT   = 3'd5,
    REG_WIN_MASKS   = 3'd6,
    REG_BACKDROP    = 3'd7
  } cfg_reg_e;

  // Effect codes of effect_control bits 7:6
  localparam logic [1:0] EffNone   = 2'd0;
  localparam logic [1:0] EffBlend  = 2'd1;
  localparam logic [1:0] EffBright = 2'd2;
  localparam logic [1:0] EffDark   = 2'd3;

  // Operation chosen per pixel for the colour stage
  typedef enum logic [2:0] {
    FX_NONE  = 3'd0,
    FX_BLEND = 3'd1,
    FX_UP    = 3'd2,
    FX_DOWN  = 3'd3,
    FX_BLANK = 3'd4
  } fx_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChans-1:0][ChanW-1:0] rgb_t;

  typedef struct packed {
    logic       elig;
    logic [3:0] key;   // {priority, layer index}: lower wins
    rgb_t       rgb;
  } lane_t;

  function automatic logic [ChanW-1:0] clamp16(input logic [ChanW-1:0] w);
    return (w > ChanW'(WeightMax)) ? ChanW'(WeightMax) : w;
  endfunction

endpackage

// File: sv/lpwb_lane.sv
module lpwb_lane import lpwb_pkg::*; (
  input  logic [PixelW-1:0] pixel_i,
  input  logic [1:0]        index_i,
  input  logic [1:0]        prio_i,
  input  logic              visible_i,
  output lane_t             lane_o
);

  // Drop the alpha bit; red leads in channel 0
  always_comb begin
    lane_o.elig   = visible_i && (pixel_i != '0);
    lane_o.key    = {prio_i, index_i};
    lane_o.rgb[0] = pixel_i[15:11];
    lane_o.rgb[1] = pixel_i[10:6];
    lane_o.rgb[2] = pixel_i[5:1];
  end

endmodule

// File: sv/lpwb_chan.sv
module lpwb_chan import lpwb_pkg::*; (
  input  fx_e              fx_i,
  input  chan_t            top_i,
  input  chan_t            bot_i,
  input  logic [ChanW-1:0] wgt_top_i,
  input  logic [ChanW-1:0] wgt_bot_i,
  input  logic [ChanW-1:0] factor_i,
  output chan_t            chan_o
);

  logic [9:0] prod_top, prod_bot, prod_up, prod_dn;
  logic [9:0] sum_blend;
  logic [5:0] sum_up;
  chan_t      inv;

  always_comb begin
    inv       = ChanMax - top_i;
    prod_top  = 10'(top_i) * 10'(wgt_top_i);
    prod_bot  = 10'(bot_i) * 10'(wgt_bot_i);
    prod_up   = 10'(inv) * 10'(factor_i);
    prod_dn   = 10'(top_i) * 10'(factor_i);
    sum_blend = prod_top + prod_bot;
    sum_up    = 6'(top_i) + 6'(prod_up[9:4]);
    case (fx_i)
      FX_BLEND: chan_o = (sum_blend[9:4] > 6'(ChanMax)) ? ChanMax : sum_blend[8:4];
      FX_UP:    chan_o = (sum_up > 6'(ChanMax)) ? ChanMax : sum_up[4:0];
      FX_DOWN:  chan_o = top_i - prod_dn[8:4];
      default:  chan_o = top_i;
    endcase
  end

endmodule

// File: sv/layer_priority_window_blend_compositor_core.sv
// Four-layer pixel compositor with windows, alpha blend and brightness.
//
// Input stream (s_axis_*): one transfer per pixel, carrying the pixel
// position and the four layer pixels in RGBA5551 (zero is transparent).
// Output stream (m_axis_*): one composited RGBA5551 pixel per input
// transfer, in order, alpha bit always set; forced blank gives all ones.
// Configuration (cfg_*): register writes by index, always ready; write
// only while no pixel is in flight.
//
// A pixel passes through the stage-one register and the output register
// before it shows on m_axis. Throughput is one pixel per cycle while the
// receiver keeps up: stage one runs the four layer lanes, the window test
// and the top-two priority merge; stage two runs three colour channel
// lanes (5x5 multiplies for blend and brightness) into the output
// register. Each stage advances when its successor is empty or moving, so
// an input transfer is still taken while a finished pixel waits, as long
// as stage one is free. When the receiver stalls the output holds and the
// pipe fills; after two held pixels s_axis_tready drops.
//
// Reset clears the configuration registers and the pipeline valid flags;
// the pixel data registers load only on a transfer.
module layer_priority_window_blend_compositor_core import lpwb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0: pixel_x[7:0], pixel_y[15:8], layer0_pixel[31:16],
  // layer1_pixel[47:32], layer2_pixel[63:48], layer3_pixel[79:64]
  input  logic [79:0]          s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: out_pixel[15:0]
  output logic [PixelW-1:0]    m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  // Configuration registers
  logic [14:0] layer_ctrl_q;
  logic [13:0] effect_ctrl_q;
  logic [12:0] blend_wgt_q;
  logic [4:0]  bright_q;
  logic [31:0] win0_q, win1_q;
  logic [17:0] win_masks_q;
  logic [14:0] backdrop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_ctrl_q  <= '0;
      effect_ctrl_q <= '0;
      blend_wgt_q   <= '0;
      bright_q      <= '0;
      win0_q        <= '0;
      win1_q        <= '0;
      win_masks_q   <= '0;
      backdrop_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LAYER_CTRL:  layer_ctrl_q  <= cfg_data_i[14:0];
        REG_EFFECT_CTRL: effect_ctrl_q <= cfg_data_i[13:0];
        REG_BLEND_WGT:   blend_wgt_q   <= cfg_data_i[12:0];
        REG_BRIGHT:      bright_q      <= cfg_data_i[4:0];
        REG_WIN0_RECT:   win0_q        <= cfg_data_i;
        REG_WIN1_RECT:   win1_q        <= cfg_data_i;
        REG_WIN_MASKS:   win_masks_q   <= cfg_data_i[17:0];
        REG_BACKDROP:    backdrop_q    <= cfg_data_i[14:0];
        default:         ;
      endcase
    end
  end

  // Pipeline handshake: each stage advances when the next one can take it
  logic s1_valid_q, out_valid_q;
  logic s2_en, s1_en, in_xfer;

  assign s2_en         = !out_valid_q || m_axis_tready;
  assign s1_en         = !s1_valid_q || s2_en;
  assign s_axis_tready = s1_en;
  assign in_xfer       = s_axis_tvalid && s1_en;

  // ---------------- Stage one: window, lanes, merge ----------------
  logic [7:0] px, py;
  assign px = s_axis_tdata[7:0];
  assign py = s_axis_tdata[15:8];

  function automatic logic inside_rect(input logic [31:0] r, input logic [7:0] x,
                                       input logic [7:0] y);
    return (y >= r[15:8]) && (y < r[7:0]) && (x >= r[31:24]) && (x < r[23:16]);
  endfunction

  logic [5:0] mask;
  always_comb begin
    mask = 6'h3F;
    if (layer_ctrl_q[5:4] != 2'b00) begin
      if (layer_ctrl_q[4] && inside_rect(win0_q, px, py)) begin
        mask = win_masks_q[5:0];
      end else if (layer_ctrl_q[5] && inside_rect(win1_q, px, py)) begin
        mask = win_masks_q[11:6];
      end else begin
        mask = win_masks_q[17:12];
      end
    end
  end

  lane_t lanes [NumLayers];

  for (genvar g = 0; g < NumLayers; g++) begin : g_lane
    lpwb_lane u_lane (
      .pixel_i   (s_axis_tdata[16 + PixelW*g +: PixelW]),
      .index_i   (2'(g)),
      .prio_i    (layer_ctrl_q[7 + 2*g +: 2]),
      .visible_i (layer_ctrl_q[g] && mask[g]),
      .lane_o    (lanes[g])
    );
  end

  // Merge: rank each eligible lane by how many eligible lanes beat it
  logic [NumLayers-1:0] top_oh, bot_oh;
  logic [2:0]           rank [NumLayers];
  always_comb begin
    for (int i = 0; i < NumLayers; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NumLayers; j++) begin
        if (lanes[j].elig && (lanes[j].key < lanes[i].key)) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
      top_oh[i] = lanes[i].elig && (rank[i] == 3'd0);
      bot_oh[i] = lanes[i].elig && (rank[i] == 3'd1);
    end
  end

  rgb_t top_rgb, bot_rgb, back_rgb;
  logic top_found, bot_found;

  assign back_rgb = {backdrop_q[14:10], backdrop_q[9:5], backdrop_q[4:0]};
  assign top_found = |top_oh;
  assign bot_found = |bot_oh;

  always_comb begin
    top_rgb = back_rgb;
    bot_rgb = back_rgb;
    for (int i = 0; i < NumLayers; i++) begin
      if (top_oh[i]) top_rgb = lanes[i].rgb;
      if (bot_oh[i]) bot_rgb = lanes[i].rgb;
    end
  end

  // Target tests: layer bit of the chosen lane, or the backdrop bit
  logic hit1, hit2;
  fx_e  fx;
  assign hit1 = top_found ? |(effect_ctrl_q[3:0] & top_oh) : effect_ctrl_q[5];
  assign hit2 = bot_found ? |(effect_ctrl_q[11:8] & bot_oh) : effect_ctrl_q[13];

  always_comb begin
    fx = FX_NONE;
    if (layer_ctrl_q[6]) begin
      fx = FX_BLANK;
    end else if (mask[5]) begin
      case (effect_ctrl_q[7:6])
        EffBlend:  if (top_found && hit1 && hit2) fx = FX_BLEND;
        EffBright: if (hit1) fx = FX_UP;
        EffDark:   if (hit1) fx = FX_DOWN;
        default:   fx = FX_NONE;
      endcase
    end
  end

  fx_e  s1_fx_q;
  rgb_t s1_top_q, s1_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Payload: load on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_fx_q  <= fx;
      s1_top_q <= top_rgb;
      s1_bot_q <= bot_rgb;
    end
  end

  // ---------------- Stage two: colour channel lanes ----------------
  logic [ChanW-1:0] wgt_top, wgt_bot, factor;
  rgb_t             fin_rgb;
  logic [PixelW-1:0] pixel_d, out_pixel_q;

  assign wgt_top = clamp16(blend_wgt_q[4:0]);
  assign wgt_bot = clamp16(blend_wgt_q[12:8]);
  assign factor  = clamp16(bright_q);

  for (genvar c = 0; c < NumChans; c++) begin : g_chan
    lpwb_chan u_chan (
      .fx_i      (s1_fx_q),
      .top_i     (s1_top_q[c]),
      .bot_i     (s1_bot_q[c]),
      .wgt_top_i (wgt_top),
      .wgt_bot_i (wgt_bot),
      .factor_i  (factor),
      .chan_o    (fin_rgb[c])
    );
  end

  assign pixel_d = (s1_fx_q == FX_BLANK) ? BlankPixel
                                         : {fin_rgb[0], fin_rgb[1], fin_rgb[2], 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      out_pixel_q <= pixel_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

import lpwb_pkg::*;

// One input transfer as it travels on s_axis_tdata, pixel_x in the lowest bits.
typedef struct packed {
  logic [15:0] layer3;
  logic [15:0] layer2;
  logic [15:0] layer1;
  logic [15:0] layer0;
  logic [7:0]  pos_y;
  logic [7:0]  pos_x;
} pixel_in_t;

// Predicts each composited pixel from its own register copy and queues it
// until the matching output transfer turns up.
class composite_checker;
  logic [14:0] layer_ctrl;
  logic [13:0] effect_ctrl;
  logic [12:0] blend_wgt;
  logic [4:0]  bright_step;
  logic [31:0] win0_rect;
  logic [31:0] win1_rect;
  logic [17:0] win_masks;
  logic [14:0] backdrop;
  logic [15:0] pending_pixels[$];
  int          mismatches;
  int          compared;

  function new();
    layer_ctrl  = '0;
    effect_ctrl = '0;
    blend_wgt   = '0;
    bright_step = '0;
    win0_rect   = '0;
    win1_rect   = '0;
    win_masks   = '0;
    backdrop    = '0;
    mismatches  = 0;
    compared    = 0;
  endfunction

  function void write_reg(cfg_reg_e idx, logic [31:0] val);
    case (idx)
      REG_LAYER_CTRL:  layer_ctrl  = val[14:0];
      REG_EFFECT_CTRL: effect_ctrl = val[13:0];
      REG_BLEND_WGT:   blend_wgt   = val[12:0];
      REG_BRIGHT:      bright_step = val[4:0];
      REG_WIN0_RECT:   win0_rect   = val;
      REG_WIN1_RECT:   win1_rect   = val;
      REG_WIN_MASKS:   win_masks   = val[17:0];
      REG_BACKDROP:    backdrop    = val[14:0];
      default: ;
    endcase
  endfunction

  static function int weight_cap(logic [4:0] w);
    return (w > 5'd16) ? 16 : int'(w);
  endfunction

  static function bit in_rect(logic [31:0] r, logic [7:0] x, logic [7:0] y);
    return (y >= r[15:8]) && (y < r[7:0]) && (x >= r[31:24]) && (x < r[23:16]);
  endfunction

  function logic [14:0] blend_rgb(logic [14:0] a, logic [14:0] b);
    int ea, eb, v;
    logic [14:0] res;
    ea = weight_cap(blend_wgt[4:0]);
    eb = weight_cap(blend_wgt[12:8]);
    for (int k = 0; k < 3; k++) begin
      v = (int'(a[5*k +: 5]) * ea + int'(b[5*k +: 5]) * eb) / 16;
      res[5*k +: 5] = 5'((v > 31) ? 31 : v);
    end
    return res;
  endfunction

  function logic [14:0] shade_rgb(logic [14:0] c, bit up);
    int f, v, n;
    logic [14:0] res;
    f = weight_cap(bright_step);
    for (int k = 0; k < 3; k++) begin
      v = int'(c[5*k +: 5]);
      if (up) begin
        n = v + (31 - v) * f / 16;
        if (n > 31) n = 31;
      end else begin
        n = v - v * f / 16;
      end
      res[5*k +: 5] = 5'(n);
    end
    return res;
  endfunction

  function logic [15:0] composite_pixel(pixel_in_t p);
    logic [5:0]  mask, tgt1, tgt2, tbit, bbit;
    logic [14:0] top, bot, fin;
    logic [15:0] lp[4];
    logic [1:0]  eff;
    int          top_idx, bot_idx;
    if (layer_ctrl[6]) return BlankPixel;
    mask = 6'h3F;
    if (|layer_ctrl[5:4]) begin
      if (layer_ctrl[4] && in_rect(win0_rect, p.pos_x, p.pos_y)) begin
        mask = win_masks[5:0];
      end else if (layer_ctrl[5] && in_rect(win1_rect, p.pos_x, p.pos_y)) begin
        mask = win_masks[11:6];
      end else begin
        mask = win_masks[17:12];
      end
    end
    lp[0] = p.layer0;
    lp[1] = p.layer1;
    lp[2] = p.layer2;
    lp[3] = p.layer3;
    top = backdrop;
    bot = backdrop;
    top_idx = -1;
    bot_idx = -1;
    // walk priorities front to back, lower index first within a priority
    for (int pr = 0; pr < 4; pr++) begin
      for (int i = 0; i < 4; i++) begin
        if (bot_idx < 0 && layer_ctrl[7 + 2*i +: 2] == 2'(pr) && layer_ctrl[i] &&
            mask[i] && lp[i] != 16'h0000) begin
          if (top_idx < 0) begin
            top = {lp[i][5:1], lp[i][10:6], lp[i][15:11]};
            top_idx = i;
          end else begin
            bot = {lp[i][5:1], lp[i][10:6], lp[i][15:11]};
            bot_idx = i;
          end
        end
      end
    end
    eff  = effect_ctrl[7:6];
    tgt1 = effect_ctrl[5:0];
    tgt2 = effect_ctrl[13:8];
    tbit = (top_idx < 0) ? 6'h20 : 6'(1 << top_idx);
    bbit = (bot_idx < 0) ? 6'h20 : 6'(1 << bot_idx);
    fin = top;
    if (mask[5]) begin
      if (eff == EffBlend && top_idx >= 0 && |(tgt1 & tbit) && |(tgt2 & bbit)) begin
        fin = blend_rgb(top, bot);
      end else if (eff == EffBright && |(tgt1 & tbit)) begin
        fin = shade_rgb(top, 1'b1);
      end else if (eff == EffDark && |(tgt1 & tbit)) begin
        fin = shade_rgb(top, 1'b0);
      end
    end
    return {fin[4:0], fin[9:5], fin[14:10], 1'b1};
  endfunction

  function void note_input(pixel_in_t p);
    pending_pixels.push_back(composite_pixel(p));
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_output(logic [15:0] got);
    logic [15:0] want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("out_pixel %h with no pixel outstanding", got));
    end else begin
      want = pending_pixels.pop_front();
      compared++;
      if (got !== want) begin
        report_mismatch($sformatf("out_pixel got %h, expected %h", got, want));
      end
    end
  endtask
endclass

module tb;

  // Generous bound on the length of the whole run.
  localparam int CycleLimit = 400000;
  // Items per register setting in the random part.
  localparam int RandPerSetting = 95;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  // Fields from bit 0: pixel_x, pixel_y, layer0_pixel .. layer3_pixel
  logic [79:0]          s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // Fields from bit 0: out_pixel
  logic [PixelW-1:0]    m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = REG_LAYER_CTRL;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  composite_checker chk = new();

  int send_idle_pct = 0;   // chance in a hundred that the sender skips a cycle
  int recv_idle_pct = 0;   // chance in a hundred that the receiver stalls
  int cycle_count   = 0;
  int pixels_sent   = 0;
  int settings_used = 1;   // the reset state counts as the first

  layer_priority_window_blend_compositor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: give up if the run hangs on a handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: compare each accepted transfer, then pick the next
  // cycle's ready at random. Values read here are the ones seen at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chk.check_output(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic pixel_in_t pixel_item(logic [7:0] x, logic [7:0] y, logic [15:0] l0,
                                           logic [15:0] l1, logic [15:0] l2,
                                           logic [15:0] l3);
    pixel_in_t p;
    p.pos_x  = x;
    p.pos_y  = y;
    p.layer0 = l0;
    p.layer1 = l1;
    p.layer2 = l2;
    p.layer3 = l3;
    return p;
  endfunction

  // Transparent, opaque black (alpha bit only) or any colour.
  function automatic logic [15:0] random_layer();
    case ($urandom_range(7))
      0, 1:    return 16'h0000;
      2:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one pixel, idling at random first; return once it has transferred.
  task automatic send_pixel(pixel_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    chk.note_input(p);
    pixels_sent++;
  endtask

  // Drop valid and hold until every predicted pixel has come out, then let
  // the two-stage pipe settle a little longer.
  task automatic hold_until_empty();
    s_axis_tvalid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load all eight registers, only ever with the pipe empty.
  task automatic apply_setup(logic [31:0] lc, logic [31:0] ec, logic [31:0] bw,
                             logic [31:0] bf, logic [31:0] w0, logic [31:0] w1,
                             logic [31:0] wm, logic [31:0] bd);
    hold_until_empty();
    write_reg(REG_LAYER_CTRL, lc);
    write_reg(REG_EFFECT_CTRL, ec);
    write_reg(REG_BLEND_WGT, bw);
    write_reg(REG_BRIGHT, bf);
    write_reg(REG_WIN0_RECT, w0);
    write_reg(REG_WIN1_RECT, w1);
    write_reg(REG_WIN_MASKS, wm);
    write_reg(REG_BACKDROP, bd);
    settings_used++;
  endtask

  // Window rectangle: mostly a sensible box, which may still come out empty
  // or inverted when the right or bottom edge wraps; sometimes pure noise.
  function automatic logic [31:0] random_rect();
    logic [7:0] l, t;
    if ($urandom_range(4) == 0) return $urandom;
    l = 8'($urandom_range(0, 200));
    t = 8'($urandom_range(0, 200));
    return {l, 8'(l + $urandom_range(0, 120)), t, 8'(t + $urandom_range(0, 120))};
  endfunction

  task automatic random_setup(int flavour);
    logic [31:0] lc;
    case (flavour)
      // every register at its top value: forced blank wins
      0: apply_setup(32'h7FFF, 32'h3FFF, 32'h1FFF, 32'h1F,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFFF, 32'h7FFF);
      // the same with blank cleared; both windows span nothing
      1: apply_setup(32'h7FBF, 32'h3FFF, 32'h1FFF, 32'h1F,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFFF, 32'h7FFF);
      default: begin
        lc = 32'($urandom_range(0, 32767));
        lc[6] = ($urandom_range(7) == 0);
        if ($urandom_range(3) != 0) lc[3:0] = 4'hF;
        apply_setup(lc, 32'($urandom_range(0, 16383)), 32'($urandom_range(0, 8191)),
                    32'($urandom_range(0, 31)), random_rect(), random_rect(),
                    32'($urandom_range(0, 262143)), 32'($urandom_range(0, 32767)));
      end
    endcase
  endtask

  initial begin
    // Reset once, released on a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the idlers off.
    // Reset state: no layer enabled, so the black backdrop shows.
    send_pixel(pixel_item(8'd239, 8'd159, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // No windows, blend on all targets, top weight clamped, white backdrop.
    // Priorities: layer 1 front, layers 2 and 3 tied behind it, layer 0 last.
    apply_setup(32'h298F, 32'h3F7F, 32'h101F, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF);
    send_pixel(pixel_item(8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pixel_item(8'd5, 8'd5, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    send_pixel(pixel_item(8'd7, 8'd9, 16'h0000, 16'h0000, 16'h0001, 16'h8421));
    send_pixel(pixel_item(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel_item(8'd240, 8'd160, 16'h1234, 16'h0000, 16'h0000, 16'h0000));

    // Both windows on, window 1 covers the frame but its last row and column, brighten with the step
    // clamped. Probe the half-open edges and the precedence of window 0.
    apply_setup(32'h003F, 32'h00BF, 32'h0, 32'h1F, 32'h0A14_0A14, 32'h00FF_00FF,
                32'h0C8FF, 32'h001F);
    send_pixel(pixel_item(8'd10, 8'd10, 16'h8001, 16'h4003, 16'h2005, 16'h1007));
    send_pixel(pixel_item(8'd19, 8'd19, 16'h8001, 16'h4003, 16'h2005, 16'h1007));
    send_pixel(pixel_item(8'd20, 8'd15, 16'h8001, 16'h4003, 16'h2005, 16'h1007));
    send_pixel(pixel_item(8'd15, 8'd20, 16'h8001, 16'h4003, 16'h2005, 16'h1007));
    send_pixel(pixel_item(8'd255, 8'd255, 16'h8001, 16'h4003, 16'h2005, 16'h1007));
    send_pixel(pixel_item(8'd0, 8'd0, 16'h0000, 16'hF801, 16'h2005, 16'h1007));

    // Only window 1 enabled and inverted; window 0 would cover nearly all but is
    // off. The outside mask hides every layer and darkens the backdrop.
    apply_setup(32'h0DAF, 32'h00E0, 32'h0, 32'h10, 32'h00FF_00FF, 32'h3228_0050,
                32'h20000, 32'h7FFF);
    send_pixel(pixel_item(8'd50, 8'd45, 16'hFFFF, 16'h0001, 16'h1111, 16'h2222));
    send_pixel(pixel_item(8'd5, 8'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Forced blank with every other register at its top value.
    random_setup(0);
    send_pixel(pixel_item(8'd1, 8'd2, 16'h5A5A, 16'hA5A5, 16'h0000, 16'h0001));
    send_pixel(pixel_item(8'd128, 8'd64, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Random part: three idling modes, four register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 30; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        random_setup((s == 0 && mode < 2) ? mode : 2);
        for (int n = 0; n < RandPerSetting; n++) begin
          // halfway through, starve the block until it has emptied
          if (n == RandPerSetting / 2) hold_until_empty();
          send_pixel(pixel_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                random_layer(), random_layer(), random_layer(),
                                random_layer()));
        end
      end
    end

    hold_until_empty();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d pixels under %0d register settings, %0d outputs compared.",
             pixels_sent, settings_used, chk.compared);
    $display("Covered blank, windows, priorities, blend and brightness under stalls.");
    if (chk.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
